### rtl/core/quasi_pr_controller_core_macros.svh
// ----------------------------------------------------------------------------
// quasi_pr_controller_core_macros.svh
// Assertion macros shared by the controller core RTL. Both expect clk and
// arst_n in scope, and both compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef QUASI_PR_CONTROLLER_CORE_MACROS_SVH
`define QUASI_PR_CONTROLLER_CORE_MACROS_SVH

`ifndef SYNTHESIS
// property that must hold at every edge out of reset
`define QPR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// expression that must never be true out of reset
`define QPR_ASSERT_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define QPR_ASSERT(lbl, prop, msg)
`define QPR_ASSERT_NEVER(lbl, expr, msg)
`endif

`endif

### rtl/core/qpr_pkg.sv
// ----------------------------------------------------------------------------
// qpr_pkg
// Types, constants and the microcode table of the quasi-PR controller core.
// ----------------------------------------------------------------------------
package qpr_pkg;

	// default widths
	localparam int SAMPLE_WIDTH_DEF = 16;
	localparam int COEF_WIDTH_DEF   = 32;

	// fixed register widths
	localparam int RES_W     = 32;
	localparam int LIM_W     = 31;
	localparam int NUM_COEF  = 5;
	localparam int REG_IDX_W = 3;

	localparam logic [LIM_W-1:0] LIMIT_RST = 31'd1000;
	localparam logic [LIM_W-1:0] RECIP_RST = 31'd2147484;

	localparam logic signed [RES_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [RES_W-1:0] RES_MIN = 32'sh8000_0000;

	// configuration register indexes
	typedef enum logic [REG_IDX_W-1:0] {
		REG_B0    = 3'd0,
		REG_B1    = 3'd1,
		REG_B2    = 3'd2,
		REG_A1    = 3'd3,
		REG_A2    = 3'd4,
		REG_LIMIT = 3'd5,
		REG_RECIP = 3'd6
	} reg_idx_t;

	// multiplier operand pairs
	typedef enum logic [2:0] {
		MUL_NONE = 3'd0,
		MUL_B0E  = 3'd1,
		MUL_B1E1 = 3'd2,
		MUL_B2E2 = 3'd3,
		MUL_A1R1 = 3'd4,
		MUL_A2R2 = 3'd5,
		MUL_RC   = 3'd6
	} mul_sel_t;

	// accumulator operations
	typedef enum logic [2:0] {
		ACC_HOLD    = 3'd0,
		ACC_ADD     = 3'd1,
		ACC_SUB     = 3'd2,
		ACC_LD_FRAC = 3'd3,
		ACC_LD_DRV  = 3'd4
	} acc_op_t;

	// jump conditions
	typedef enum logic [1:0] {
		COND_NONE     = 2'd0,
		COND_ALWAYS   = 2'd1,
		COND_NO_IN    = 2'd2,
		COND_OUT_BUSY = 2'd3
	} cond_t;

	localparam int STEP_W = 4;
	typedef logic [STEP_W-1:0] step_t;

	// program steps
	localparam step_t ST_IDLE  = 4'd0;
	localparam step_t ST_B0E   = 4'd1;
	localparam step_t ST_B1E1  = 4'd2;
	localparam step_t ST_B2E2  = 4'd3;
	localparam step_t ST_A1R1  = 4'd4;
	localparam step_t ST_A2R2  = 4'd5;
	localparam step_t ST_LAST_SUB = 4'd6;
	localparam step_t ST_SAT   = 4'd7;
	localparam step_t ST_CLAMP = 4'd8;
	localparam step_t ST_SCALE = 4'd9;
	localparam step_t ST_SC_ADD = 4'd10;
	localparam step_t ST_OUT   = 4'd11;
	localparam step_t LAST_STEP = ST_OUT;

	// one control word
	typedef struct packed {
		logic     accept;
		mul_sel_t mul_sel;
		acc_op_t  acc_op;
		logic     upd_hist;
		logic     do_clamp;
		logic     load_out;
		cond_t    cond;
		step_t    target;
		logic     last;
	} ctrl_t;

	// sequencer condition inputs
	typedef struct packed {
		logic in_valid;
		logic out_busy;
	} status_t;

	localparam ctrl_t CTRL_NOP = '{
		accept:   1'b0,
		mul_sel:  MUL_NONE,
		acc_op:   ACC_HOLD,
		upd_hist: 1'b0,
		do_clamp: 1'b0,
		load_out: 1'b0,
		cond:     COND_NONE,
		target:   ST_IDLE,
		last:     1'b0
	};

	// microcode ROM: products are registered, so each add follows its multiply
	function automatic ctrl_t ucode(input step_t step);
		ctrl_t w;
		w = CTRL_NOP;
		case (step)
			ST_IDLE: begin
				w.accept = 1'b1;
				w.acc_op = ACC_LD_FRAC;
				w.cond   = COND_NO_IN;
				w.target = ST_IDLE;
			end
			ST_B0E: begin
				w.mul_sel = MUL_B0E;
			end
			ST_B1E1: begin
				w.mul_sel = MUL_B1E1;
				w.acc_op  = ACC_ADD;
			end
			ST_B2E2: begin
				w.mul_sel = MUL_B2E2;
				w.acc_op  = ACC_ADD;
			end
			ST_A1R1: begin
				w.mul_sel = MUL_A1R1;
				w.acc_op  = ACC_ADD;
			end
			ST_A2R2: begin
				w.mul_sel = MUL_A2R2;
				w.acc_op  = ACC_SUB;
			end
			ST_LAST_SUB: begin
				w.acc_op = ACC_SUB;
			end
			ST_SAT: begin
				w.upd_hist = 1'b1;
				w.acc_op   = ACC_LD_DRV;
			end
			ST_CLAMP: begin
				w.do_clamp = 1'b1;
			end
			ST_SCALE: begin
				w.mul_sel = MUL_RC;
			end
			ST_SC_ADD: begin
				w.acc_op = ACC_ADD;
			end
			ST_OUT: begin
				w.load_out = 1'b1;
				w.cond     = COND_OUT_BUSY;
				w.target   = ST_OUT;
				w.last     = 1'b1;
			end
			default: begin
				w.cond   = COND_ALWAYS;
				w.target = ST_IDLE;
			end
		endcase
		return w;
	endfunction

endpackage

### rtl/core/quasi_pr_controller_core.sv
// Quasi-PR controller core.
// A new input is taken only in the idle step; each item then runs the whole
// 12-step microprogram driving one shared multiply-accumulate unit, and its result
// is loaded once the output is free; a stalled output holds the program.
// Reset clears history to zero, coefficients to zero, limit to 1000 and its
// reciprocal to 2147484; the sequencer returns to its idle step.
// ----------------------------------------------------------------------------
// quasi_pr_controller_core
// Top level: configuration registers, handshakes and output valid.
// ----------------------------------------------------------------------------
`include "quasi_pr_controller_core_macros.svh"

module quasi_pr_controller_core #(
	parameter int SAMPLE_WIDTH = qpr_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = qpr_pkg::COEF_WIDTH_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	// configuration
	input  logic                                            cfg_wr_en,
	input  logic [qpr_pkg::REG_IDX_W-1:0]                   cfg_index,
	input  logic [((COEF_WIDTH > 31) ? COEF_WIDTH : 31)-1:0] cfg_wdata,
	// input channel
	input  logic                                            in_valid,
	output logic                                            in_stall,
	input  logic signed [SAMPLE_WIDTH-1:0]                  setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0]                  measured,
	// output channel
	output logic                                            out_valid,
	input  logic                                            out_stall,
	output logic signed [SAMPLE_WIDTH-1:0]                  drive,
	output logic                                            clamped
);

	logic signed [COEF_WIDTH-1:0]     coef_q [qpr_pkg::NUM_COEF];
	logic        [qpr_pkg::LIM_W-1:0] limit_q;
	logic        [qpr_pkg::LIM_W-1:0] recip_q;
	qpr_pkg::ctrl_t                   ctrl;
	qpr_pkg::status_t                 status;
	logic                             in_xfer;
	logic                             out_busy;
	logic                             out_load;
	logic                             out_valid_q;

	// configuration registers; unknown indexes are ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qpr_pkg::NUM_COEF; i++) begin
				coef_q[i] <= '0;
			end
			limit_q <= qpr_pkg::LIMIT_RST;
			recip_q <= qpr_pkg::RECIP_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				qpr_pkg::REG_B0, qpr_pkg::REG_B1, qpr_pkg::REG_B2,
				qpr_pkg::REG_A1, qpr_pkg::REG_A2: begin
					coef_q[cfg_index] <= cfg_wdata[COEF_WIDTH-1:0];
				end
				qpr_pkg::REG_LIMIT: limit_q <= cfg_wdata[qpr_pkg::LIM_W-1:0];
				qpr_pkg::REG_RECIP: recip_q <= cfg_wdata[qpr_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// handshakes
	assign in_stall = ~ctrl.accept;
	assign in_xfer  = in_valid & ctrl.accept;
	assign out_busy = out_valid_q & out_stall;
	assign out_load = ctrl.load_out & ~out_busy;

	assign status.in_valid = in_valid;
	assign status.out_busy = out_busy;

	// output valid: set on load, cleared once the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

	qpr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.ctrl   (ctrl)
	);

	qpr_dp #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.COEF_WIDTH   (COEF_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.in_xfer     (in_xfer),
		.out_load    (out_load),
		.setpoint    (setpoint),
		.measured    (measured),
		.coef        (coef_q),
		.limit       (limit_q),
		.limit_recip (recip_q),
		.drive       (drive),
		.clamped     (clamped)
	);

	`QPR_ASSERT(a_out_rise_on_load, $rose(out_valid_q) |-> $past(out_load),
		"output valid rose without a result load")
	`QPR_ASSERT_NEVER(a_load_over_pending, out_load && out_valid_q && out_stall,
		"result loaded over a stalled transfer")

endmodule

### rtl/core/qpr_seq.sv
// ----------------------------------------------------------------------------
// qpr_seq
// Step counter and microcode ROM; issues one control word per cycle.
// ----------------------------------------------------------------------------
`include "quasi_pr_controller_core_macros.svh"

module qpr_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  qpr_pkg::status_t status,
	output qpr_pkg::ctrl_t   ctrl
);

	qpr_pkg::step_t step_q;
	qpr_pkg::step_t step_nxt;
	logic           jump;

	// ROM look-up
	assign ctrl = qpr_pkg::ucode(step_q);

	// jump condition
	always_comb begin
		case (ctrl.cond)
			qpr_pkg::COND_ALWAYS:   jump = 1'b1;
			qpr_pkg::COND_NO_IN:    jump = ~status.in_valid;
			qpr_pkg::COND_OUT_BUSY: jump = status.out_busy;
			default:                jump = 1'b0;
		endcase
	end

	// next step: jump, wrap at end of program, or advance
	always_comb begin
		if (jump) begin
			step_nxt = ctrl.target;
		end else if (ctrl.last) begin
			step_nxt = qpr_pkg::ST_IDLE;
		end else begin
			step_nxt = step_q + qpr_pkg::step_t'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= qpr_pkg::ST_IDLE;
		end else begin
			step_q <= step_nxt;
		end
	end

	`QPR_ASSERT_NEVER(a_step_range, step_q > qpr_pkg::LAST_STEP, "step beyond end of program")
	`QPR_ASSERT(a_leave_idle_on_input,
		(step_q == qpr_pkg::ST_B0E) |-> ($past(step_q) == qpr_pkg::ST_IDLE && $past(status.in_valid)),
		"sequencer started without an input transfer")

endmodule

### rtl/core/qpr_dp.sv
// ----------------------------------------------------------------------------
// qpr_dp
// Datapath: error and history registers, shared multiplier with registered
// product, accumulator, saturation, clamp and output registers.
// ----------------------------------------------------------------------------
module qpr_dp #(
	parameter int SAMPLE_WIDTH = qpr_pkg::SAMPLE_WIDTH_DEF,
	parameter int COEF_WIDTH   = qpr_pkg::COEF_WIDTH_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  qpr_pkg::ctrl_t                       ctrl,
	input  logic                                 in_xfer,
	input  logic                                 out_load,
	input  logic signed [SAMPLE_WIDTH-1:0]       setpoint,
	input  logic signed [SAMPLE_WIDTH-1:0]       measured,
	input  logic signed [COEF_WIDTH-1:0]         coef [qpr_pkg::NUM_COEF],
	input  logic        [qpr_pkg::LIM_W-1:0]     limit,
	input  logic        [qpr_pkg::LIM_W-1:0]     limit_recip,
	output logic signed [SAMPLE_WIDTH-1:0]       drive,
	output logic                                 clamped
);

	localparam int EW        = SAMPLE_WIDTH + 1;
	localparam int AW        = (COEF_WIDTH > 32) ? COEF_WIDTH : 32;
	localparam int BW        = qpr_pkg::RES_W;
	localparam int PW        = AW + BW;
	localparam int ACC_W     = AW + BW + 4;
	localparam int FRAC_BITS = COEF_WIDTH - 8;
	localparam int DRV_SHIFT = 32 - SAMPLE_WIDTH;
	localparam int LW        = qpr_pkg::LIM_W + 2;

	localparam logic [ACC_W-1:0] ACC_ONE  = {{(ACC_W-1){1'b0}}, 1'b1};
	localparam logic [ACC_W-1:0] RND_FRAC = ACC_ONE << (FRAC_BITS - 1);
	localparam logic [ACC_W-1:0] RND_DRV  = ACC_ONE << (DRV_SHIFT - 1);

	localparam logic signed [SAMPLE_WIDTH-1:0] DRV_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
	localparam logic signed [SAMPLE_WIDTH-1:0] DRV_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

	logic signed [EW-1:0]        err_in;
	logic signed [EW-1:0]        err_q;
	logic signed [EW-1:0]        err_prev1_q;
	logic signed [EW-1:0]        err_prev2_q;
	logic signed [BW-1:0]        res_prev1_q;
	logic signed [BW-1:0]        res_prev2_q;
	logic signed [BW-1:0]        c_q;
	logic                        clamp_q;
	logic signed [AW-1:0]        a_op;
	logic signed [BW-1:0]        b_op;
	logic signed [PW-1:0]        prod;
	logic signed [PW-1:0]        prod_s1;
	logic signed [ACC_W-1:0]     acc_q;
	logic signed [ACC_W-1:0]     sum_sh;
	logic signed [ACC_W-1:0]     drv_sh;
	logic signed [BW-1:0]        r_sat;
	logic signed [SAMPLE_WIDTH-1:0] drv_sat;
	logic signed [LW-1:0]        lim_s;
	logic signed [LW-1:0]        r_w;
	logic                        r_ge;
	logic                        r_le;
	logic signed [BW-1:0]        c_nxt;
	logic signed [SAMPLE_WIDTH-1:0] drive_q;
	logic                        clamped_q;

	// error, exact in one extra bit
	assign err_in = EW'(setpoint) - EW'(measured);

	// operand selection for the shared multiplier
	always_comb begin
		case (ctrl.mul_sel)
			qpr_pkg::MUL_B0E: begin
				a_op = AW'(coef[qpr_pkg::REG_B0]);
				b_op = BW'(err_q);
			end
			qpr_pkg::MUL_B1E1: begin
				a_op = AW'(coef[qpr_pkg::REG_B1]);
				b_op = BW'(err_prev1_q);
			end
			qpr_pkg::MUL_B2E2: begin
				a_op = AW'(coef[qpr_pkg::REG_B2]);
				b_op = BW'(err_prev2_q);
			end
			qpr_pkg::MUL_A1R1: begin
				a_op = AW'(coef[qpr_pkg::REG_A1]);
				b_op = res_prev1_q;
			end
			qpr_pkg::MUL_A2R2: begin
				a_op = AW'(coef[qpr_pkg::REG_A2]);
				b_op = res_prev2_q;
			end
			qpr_pkg::MUL_RC: begin
				a_op = AW'({1'b0, limit_recip});
				b_op = c_q;
			end
			default: begin
				a_op = '0;
				b_op = '0;
			end
		endcase
	end

	assign prod = a_op * b_op;

	// product register and accumulator
	always_ff @(posedge clk) begin
		prod_s1 <= prod;
		case (ctrl.acc_op)
			qpr_pkg::ACC_ADD:     acc_q <= acc_q + ACC_W'(prod_s1);
			qpr_pkg::ACC_SUB:     acc_q <= acc_q - ACC_W'(prod_s1);
			qpr_pkg::ACC_LD_FRAC: acc_q <= RND_FRAC;
			qpr_pkg::ACC_LD_DRV:  acc_q <= RND_DRV;
			default:              acc_q <= acc_q;
		endcase
	end

	// drop fraction bits and saturate to 32 bits
	assign sum_sh = acc_q >>> FRAC_BITS;
	always_comb begin
		if ((&sum_sh[ACC_W-1:BW-1]) || !(|sum_sh[ACC_W-1:BW-1])) begin
			r_sat = sum_sh[BW-1:0];
		end else if (sum_sh[ACC_W-1]) begin
			r_sat = qpr_pkg::RES_MIN;
		end else begin
			r_sat = qpr_pkg::RES_MAX;
		end
	end

	// error and result history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_prev1_q <= '0;
			err_prev2_q <= '0;
			res_prev1_q <= '0;
			res_prev2_q <= '0;
		end else if (ctrl.upd_hist) begin
			err_prev2_q <= err_prev1_q;
			err_prev1_q <= err_q;
			res_prev2_q <= res_prev1_q;
			res_prev1_q <= r_sat;
		end
	end

	// clamp the newest result to plus or minus the limit; touching counts
	assign lim_s = LW'({1'b0, limit});
	assign r_w   = LW'(res_prev1_q);
	assign r_ge  = (r_w >= lim_s);
	assign r_le  = (r_w <= -lim_s);
	always_comb begin
		if (r_ge) begin
			c_nxt = lim_s[BW-1:0];
		end else if (r_le) begin
			c_nxt = BW'(-lim_s);
		end else begin
			c_nxt = res_prev1_q;
		end
	end

	// scaled drive: drop shift bits and saturate to the sample range
	assign drv_sh = acc_q >>> DRV_SHIFT;
	always_comb begin
		if ((&drv_sh[ACC_W-1:SAMPLE_WIDTH-1]) || !(|drv_sh[ACC_W-1:SAMPLE_WIDTH-1])) begin
			drv_sat = drv_sh[SAMPLE_WIDTH-1:0];
		end else if (drv_sh[ACC_W-1]) begin
			drv_sat = DRV_MIN;
		end else begin
			drv_sat = DRV_MAX;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			err_q <= err_in;
		end
		if (ctrl.do_clamp) begin
			c_q     <= c_nxt;
			clamp_q <= r_ge | r_le;
		end
		if (out_load) begin
			drive_q   <= drv_sat;
			clamped_q <= clamp_q;
		end
	end

	assign drive   = drive_q;
	assign clamped = clamped_q;

endmodule
